// File: sv/m7fr_pkg.sv
// Shared types and constants for the Modem7 filename receiver.
package m7fr_pkg;

  // Filename buffer depth and the widths that follow from it.
  localparam int NAME_MAX    = 64;
  localparam int NAME_IDX_W  = 6;
  localparam int NAME_CNT_W  = 7;
  localparam logic [NAME_CNT_W-1:0] NAME_MAX_C = NAME_CNT_W'(NAME_MAX);

  // Link characters.
  localparam logic [7:0] CH_NAK   = 8'h15;
  localparam logic [7:0] CH_ACK   = 8'h06;
  localparam logic [7:0] CH_EOT   = 8'h04;
  localparam logic [7:0] CH_SUB   = 8'h1A;
  localparam logic [7:0] CH_RETRY = 8'h75;  // 'u'

  localparam logic [15:0] TICK_SAT = 16'hFFFF;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RETRY_LIMIT = 2'd0;
  localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_CHR_TIMEOUT = 2'd2;

  // Configuration reset values.
  localparam logic [3:0]  RETRY_LIMIT_RST = 4'd10;
  localparam logic [15:0] TIMEOUT_RST     = 16'd10000;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_BYTE    = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_CARRIER = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EOB     = 2'd1,
    ST_RETRY   = 2'd2,
    ST_CARRIER = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_WACK  = 2'd1,
    PH_WCHAR = 2'd2,
    PH_WOK   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] rx_byte;
  } m7fr_in_t;

  typedef struct packed {
    logic                  tx_valid;
    logic [7:0]            tx_byte;
    logic                  done_res;
    logic [1:0]            status;
    logic                  name_valid;
    logic [NAME_IDX_W-1:0] name_index;
    logic [7:0]            name_byte;
    logic                  name_overflow;
    logic [NAME_CNT_W-1:0] name_length;
  } m7fr_out_t;

  typedef struct packed {
    logic [3:0]  retry_limit;
    logic [15:0] ack_timeout;
    logic [15:0] chr_timeout;
  } m7fr_cfg_t;

  typedef struct packed {
    phase_t                phase;
    logic [3:0]            retry_count;
    logic [15:0]           tick_count;
    logic [7:0]            checksum;
    logic [NAME_CNT_W-1:0] name_count;
  } m7fr_state_t;

endpackage

// File: sv/m7fr_core.sv
// Next-state and result logic for one request of the filename receiver.
module m7fr_core (
  input  m7fr_pkg::m7fr_state_t st,
  input  m7fr_pkg::m7fr_cfg_t   cfg,
  input  m7fr_pkg::m7fr_in_t    req,
  output m7fr_pkg::m7fr_state_t st_nxt,
  output m7fr_pkg::m7fr_out_t   res,
  output logic                  has_res
);
  import m7fr_pkg::*;

  logic        do_nak;
  logic        do_fin;
  status_t     fin_status;
  logic [15:0] tick_inc;
  logic [3:0]  retry_eff;

  assign tick_inc  = (st.tick_count == TICK_SAT) ? st.tick_count : st.tick_count + 16'd1;
  assign retry_eff = (req.cmd == CMD_START) ? 4'd0 : st.retry_count;

  always_comb begin
    st_nxt     = st;
    res        = '0;
    has_res    = 1'b0;
    do_nak     = 1'b0;
    do_fin     = 1'b0;
    fin_status = ST_OK;

    if (req.cmd == CMD_START) begin
      st_nxt.retry_count = 4'd0;
      do_nak = 1'b1;
    end else begin
      case (st.phase)
        PH_WACK: begin
          case (req.cmd)
            CMD_BYTE: begin
              if (req.rx_byte == CH_ACK) begin
                st_nxt.phase      = PH_WCHAR;
                st_nxt.tick_count = 16'd0;
              end else if (req.rx_byte == CH_EOT) begin
                do_fin     = 1'b1;
                fin_status = ST_EOB;
              end
            end
            CMD_TICK: begin
              st_nxt.tick_count = tick_inc;
              do_nak = (tick_inc >= cfg.ack_timeout);
            end
            default: begin
              do_fin     = 1'b1;
              fin_status = ST_CARRIER;
            end
          endcase
        end
        PH_WCHAR: begin
          case (req.cmd)
            CMD_BYTE: begin
              if (req.rx_byte == CH_EOT) begin
                do_fin = 1'b1;
              end else if (req.rx_byte == CH_SUB) begin
                st_nxt.phase      = PH_WOK;
                st_nxt.tick_count = 16'd0;
                has_res           = 1'b1;
                res.tx_valid      = 1'b1;
                res.tx_byte       = st.checksum;
              end else if (req.rx_byte == CH_RETRY) begin
                do_nak = 1'b1;
              end else begin
                // Ordinary name byte: summed, acked, stored while room is left.
                st_nxt.checksum   = st.checksum + req.rx_byte;
                st_nxt.tick_count = 16'd0;
                has_res           = 1'b1;
                res.tx_valid      = 1'b1;
                res.tx_byte       = CH_ACK;
                res.name_byte     = req.rx_byte;
                if (st.name_count < NAME_MAX_C) begin
                  res.name_valid    = 1'b1;
                  res.name_index    = st.name_count[NAME_IDX_W-1:0];
                  st_nxt.name_count = st.name_count + NAME_CNT_W'(1);
                end else begin
                  res.name_overflow = 1'b1;
                end
              end
            end
            CMD_TICK: begin
              st_nxt.tick_count = tick_inc;
              do_nak = (tick_inc >= cfg.chr_timeout);
            end
            default: begin
            end
          endcase
        end
        PH_WOK: begin
          case (req.cmd)
            CMD_BYTE: begin
              if (req.rx_byte == CH_ACK) begin
                do_fin = 1'b1;
              end else begin
                do_nak = 1'b1;
              end
            end
            CMD_TICK: begin
              st_nxt.tick_count = tick_inc;
              do_nak = (tick_inc >= cfg.chr_timeout);
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end

    // NAK action: either give up on the retry limit or send another NAK.
    if (do_nak) begin
      if (retry_eff >= cfg.retry_limit) begin
        do_fin     = 1'b1;
        fin_status = ST_RETRY;
      end else begin
        st_nxt.retry_count = retry_eff + 4'd1;
        st_nxt.name_count  = '0;
        st_nxt.checksum    = CH_SUB;
        st_nxt.phase       = PH_WACK;
        st_nxt.tick_count  = 16'd0;
        has_res            = 1'b1;
        res.tx_valid       = 1'b1;
        res.tx_byte        = CH_NAK;
      end
    end

    if (do_fin) begin
      res               = '0;
      has_res           = 1'b1;
      res.done_res      = 1'b1;
      res.status        = fin_status;
      res.name_length   = st_nxt.name_count;
      st_nxt.phase      = PH_IDLE;
      st_nxt.tick_count = 16'd0;
    end
  end

endmodule

// File: sv/modem7_filename_receiver.sv
// Top level of the Modem7 batch filename receiver.
//
// This block runs the receive side of the Modem7 filename exchange. Each
// request carries one event: a start command, a byte from the link, one
// timer tick, or carrier loss. The block answers with at most one result
// that says which byte to send (NAK, ACK or the checksum), which filename
// byte was taken and at which position, or that the exchange ended and
// with what status. One request is taken every clock cycle while the input
// is not stalled: the whole state update for a request is done in the cycle
// it is accepted, and its result lands in a single output register in the
// cycle after. The block stalls its input only while that output register
// holds a result that the receiving side is stalling; requests that produce
// no result (ticks that do not time out, ignored bytes) never occupy the
// output register. Timeouts count requests of the tick kind, not clock
// cycles. The three configuration registers (retry limit, ACK timeout,
// character timeout) should only be written while no exchange is in progress.
module modem7_filename_receiver (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  m7fr_pkg::m7fr_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output m7fr_pkg::m7fr_out_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);
  import m7fr_pkg::*;

  m7fr_cfg_t   cfg_r;
  m7fr_state_t state_r;
  m7fr_state_t state_nxt;
  m7fr_out_t   res;
  logic        has_res;
  logic        out_valid_r;
  m7fr_out_t   out_data_r;
  logic        accept;

  // The input waits only while a result in the output register is being held back.
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  m7fr_core u_core (
    .st      (state_r),
    .cfg     (cfg_r),
    .req     (in_data),
    .st_nxt  (state_nxt),
    .res     (res),
    .has_res (has_res)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.retry_limit <= RETRY_LIMIT_RST;
      cfg_r.ack_timeout <= TIMEOUT_RST;
      cfg_r.chr_timeout <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RETRY_LIMIT: cfg_r.retry_limit <= cfg_wdata[3:0];
        CFG_ACK_TIMEOUT: cfg_r.ack_timeout <= cfg_wdata;
        CFG_CHR_TIMEOUT: cfg_r.chr_timeout <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Protocol state advances once per accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase       <= PH_IDLE;
      state_r.retry_count <= 4'd0;
      state_r.tick_count  <= 16'd0;
      state_r.checksum    <= CH_SUB;
      state_r.name_count  <= '0;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  // Output register: loaded by a request that has a result, emptied when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && has_res) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_res) begin
      out_data_r <= res;
    end
  end

  // A finished exchange always leaves the block idle.
  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && has_res && res.done_res) |=> (state_r.phase == PH_IDLE))
    else $error("exchange finished but phase did not return to idle");

  // Each stored filename byte advances the name count by exactly one.
  a_name_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && res.name_valid) |=>
      (state_r.name_count == $past(state_r.name_count) + NAME_CNT_W'(1)))
    else $error("name count did not advance with a stored name byte");

  // The name count never runs past the buffer depth.
  a_name_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.name_count <= NAME_MAX_C)
    else $error("name count beyond buffer depth");

  // The timer is always clear while idle.
  a_idle_timer_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == PH_IDLE) |-> (state_r.tick_count == 16'd0))
    else $error("tick count not clear while idle");

endmodule

// File: tb/sv/m7fr_checker.sv
`timescale 1ns / 1ps
// Watches the request and result channels of the Modem7 filename receiver and checks every result.
module m7fr_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  m7fr_pkg::m7fr_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  m7fr_pkg::m7fr_out_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata,
  output int                  errors,
  output int                  pending
);
  import m7fr_pkg::*;

  // Shadow copy of the receiver state and its registers.
  phase_t                rx_phase;
  logic [3:0]            naks_sent;
  logic [15:0]           ticks_seen;
  logic [7:0]            name_sum;
  logic [NAME_CNT_W-1:0] name_held;
  logic [3:0]            lim_retry;
  logic [15:0]           tmo_ack;
  logic [15:0]           tmo_chr;

  m7fr_out_t expected_replies[$];
  m7fr_out_t want;
  m7fr_out_t got;
  bit        has_reply;

  initial errors = 0;
  initial pending = 0;

  task automatic end_exchange(input status_t st, output m7fr_out_t r);
    r             = '0;
    r.done_res    = 1'b1;
    r.status      = st;
    r.name_length = name_held;
    rx_phase      = PH_IDLE;
    ticks_seen    = '0;
  endtask

  task automatic send_char(input logic [7:0] ch, output m7fr_out_t r);
    r          = '0;
    r.tx_valid = 1'b1;
    r.tx_byte  = ch;
  endtask

  task automatic nak_or_give_up(output m7fr_out_t r);
    if (naks_sent >= lim_retry) begin
      end_exchange(ST_RETRY, r);
    end else begin
      naks_sent  = naks_sent + 4'd1;
      name_held  = '0;
      name_sum   = CH_SUB;
      rx_phase   = PH_WACK;
      ticks_seen = '0;
      send_char(CH_NAK, r);
    end
  endtask

  function automatic bit tick_expired(input logic [15:0] tmo);
    if (ticks_seen != TICK_SAT) ticks_seen = ticks_seen + 16'd1;
    return ticks_seen >= tmo;
  endfunction

  task automatic step_receiver(input m7fr_in_t req, output bit has, output m7fr_out_t r);
    has = 1'b0;
    r   = '0;
    if (req.cmd == CMD_START) begin
      naks_sent = '0;
      nak_or_give_up(r);
      has = 1'b1;
    end else begin
      case (rx_phase)
        PH_WACK: begin
          case (req.cmd)
            CMD_BYTE: begin
              if (req.rx_byte == CH_ACK) begin
                rx_phase   = PH_WCHAR;
                ticks_seen = '0;
              end else if (req.rx_byte == CH_EOT) begin
                end_exchange(ST_EOB, r);
                has = 1'b1;
              end
            end
            CMD_TICK: begin
              if (tick_expired(tmo_ack)) begin
                nak_or_give_up(r);
                has = 1'b1;
              end
            end
            default: begin
              end_exchange(ST_CARRIER, r);
              has = 1'b1;
            end
          endcase
        end
        PH_WCHAR: begin
          if (req.cmd == CMD_BYTE) begin
            has = 1'b1;
            if (req.rx_byte == CH_EOT) begin
              end_exchange(ST_OK, r);
            end else if (req.rx_byte == CH_SUB) begin
              rx_phase   = PH_WOK;
              ticks_seen = '0;
              send_char(name_sum, r);
            end else if (req.rx_byte == CH_RETRY) begin
              nak_or_give_up(r);
            end else begin
              name_sum    = name_sum + req.rx_byte;
              r.tx_valid  = 1'b1;
              r.tx_byte   = CH_ACK;
              r.name_byte = req.rx_byte;
              if (name_held < NAME_MAX_C) begin
                r.name_valid = 1'b1;
                r.name_index = name_held[NAME_IDX_W-1:0];
                name_held    = name_held + NAME_CNT_W'(1);
              end else begin
                r.name_overflow = 1'b1;
              end
              ticks_seen = '0;
            end
          end else if (req.cmd == CMD_TICK && tick_expired(tmo_chr)) begin
            nak_or_give_up(r);
            has = 1'b1;
          end
        end
        PH_WOK: begin
          if (req.cmd == CMD_BYTE) begin
            has = 1'b1;
            if (req.rx_byte == CH_ACK) end_exchange(ST_OK, r);
            else nak_or_give_up(r);
          end else if (req.cmd == CMD_TICK && tick_expired(tmo_chr)) begin
            nak_or_give_up(r);
            has = 1'b1;
          end
        end
        default: ;
      endcase
    end
  endtask

  task automatic check_field(input string fname, input logic [7:0] exp, input logic [7:0] act);
    if (exp !== act) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, exp, act);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rx_phase   = PH_IDLE;
      naks_sent  = '0;
      ticks_seen = '0;
      name_sum   = CH_SUB;
      name_held  = '0;
      lim_retry  = RETRY_LIMIT_RST;
      tmo_ack    = TIMEOUT_RST;
      tmo_chr    = TIMEOUT_RST;
      expected_replies.delete();
    end else begin
      // The result register is loaded at the edge that accepts its request, so a result taken at this
      // edge always belongs to an earlier request: check it before adding the new one.
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        end else begin
          want = expected_replies.pop_front();
          check_field("tx_valid", want.tx_valid, out_data.tx_valid);
          check_field("tx_byte", want.tx_byte, out_data.tx_byte);
          check_field("done_res", want.done_res, out_data.done_res);
          check_field("status", want.status, out_data.status);
          check_field("name_valid", want.name_valid, out_data.name_valid);
          check_field("name_index", want.name_index, out_data.name_index);
          check_field("name_byte", want.name_byte, out_data.name_byte);
          check_field("name_overflow", want.name_overflow, out_data.name_overflow);
          check_field("name_length", want.name_length, out_data.name_length);
        end
      end
      if (in_valid && !in_stall) begin
        step_receiver(in_data, has_reply, got);
        if (has_reply) expected_replies.push_back(got);
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_RETRY_LIMIT: lim_retry = cfg_wdata[3:0];
          CFG_ACK_TIMEOUT: tmo_ack   = cfg_wdata;
          CFG_CHR_TIMEOUT: tmo_chr   = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending = expected_replies.size();
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the Modem7 filename receiver testbench: clock, reset, stimulus and verdict.
module tb_top;
  import m7fr_pkg::*;

  // Cycle limit for the watchdog; it is meant to cover even the heavy idling
  // modes and the long hold-off with a wide margin.
  localparam int LIMIT = 400000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  m7fr_in_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  m7fr_out_t   out_data;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = CFG_RETRY_LIMIT;
  logic [15:0] cfg_wdata = '0;

  int errors;
  int pending;
  int cycles      = 0;
  int tx_idle_pct = 6;
  int rx_idle_pct = 60;
  int hold_seq    = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int n_sent      = 0;

  // The stimulus keeps its own copy of the register values so that it knows
  // how many ticks it takes to run a wait into its timeout.
  logic [3:0]  cur_lim = RETRY_LIMIT_RST;
  logic [15:0] cur_ack = TIMEOUT_RST;
  logic [15:0] cur_chr = TIMEOUT_RST;

  modem7_filename_receiver i_dut (.*);

  m7fr_checker i_checker (.*);

  always #1 clk = ~clk;

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver side. Normally it stalls at random with the current idle rate.
  // When the stimulus bumps hold_seq, it holds the result channel off for a
  // long stretch; the sender keeps offering requests meanwhile, so the block's
  // output register fills up and the block has to stall its input.
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // Offers one request and returns at the edge where it was taken. Random idle
  // cycles may come first. The stall is sampled at the falling edge, where it is
  // settled, so acceptance never depends on event order at the rising edge.
  task automatic offer(input cmd_t cmd, input logic [7:0] b, input bit counted);
    bit stalled;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data.cmd     <= cmd;
    in_data.rx_byte <= b;
    stalled = 1'b1;
    while (stalled) begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end
    if (counted) n_sent++;
  endtask

  // Sends enough ticks to run a wait with this timeout out, or a handful when
  // the timeout is too long to reach.
  task automatic tick_burst(input logic [15:0] tmo);
    int n;
    n = (tmo <= 16'd20) ? int'(tmo) : $urandom_range(1, 20);
    repeat (n) offer(CMD_TICK, 8'($urandom), 1'b1);
  endtask

  // Drops valid and waits until every expected result has come back, then lets
  // the clock run on before returning.
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // Writes all three registers on consecutive cycles; the block must be idle.
  task automatic apply_cfg(input logic [3:0] lim, input logic [15:0] ack, input logic [15:0] chr);
    cur_lim = lim;
    cur_ack = ack;
    cur_chr = chr;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RETRY_LIMIT;
    cfg_wdata <= {12'd0, lim};
    @(posedge clk);
    cfg_index <= CFG_ACK_TIMEOUT;
    cfg_wdata <= ack;
    @(posedge clk);
    cfg_index <= CFG_CHR_TIMEOUT;
    cfg_wdata <= chr;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One filename exchange as a sender would run it, with random content and
  // an occasional wrong turn: early EOT, carrier loss, runs of retries,
  // timeouts, stray ticks and carrier drops in the middle of the name, long
  // names that overflow the buffer, and bad checksum replies.
  task automatic session();
    int         r;
    int         len;
    logic [7:0] b;
    offer(CMD_START, 8'($urandom), 1'b1);
    if ($urandom_range(0, 99) < 20) begin
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 1)) begin
          do b = 8'($urandom); while (b == CH_ACK || b == CH_EOT);
          offer(CMD_BYTE, b, 1'b1);
        end else begin
          offer(CMD_TICK, 8'($urandom), 1'b1);
        end
      end
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      offer(CMD_BYTE, CH_EOT, 1'b1);
      return;
    end
    if (r < 14) begin
      offer(CMD_CARRIER, 8'($urandom), 1'b1);
      return;
    end
    if (r < 24) begin
      // Repeated NAKs without a fresh start, to reach the retry limit.
      repeat ($urandom_range(1, 16)) begin
        if (cur_ack <= 16'd20 && $urandom_range(0, 1)) begin
          tick_burst(cur_ack);
        end else begin
          offer(CMD_BYTE, CH_ACK, 1'b1);
          offer(CMD_BYTE, CH_RETRY, 1'b1);
        end
      end
      return;
    end
    if (r < 30) begin
      tick_burst(cur_ack);
      return;
    end
    offer(CMD_BYTE, CH_ACK, 1'b1);
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 12);
    repeat (len) begin
      if ($urandom_range(0, 99) < 4) offer(CMD_TICK, 8'($urandom), 1'b1);
      if ($urandom_range(0, 99) < 3) offer(CMD_CARRIER, 8'($urandom), 1'b1);
      do b = 8'($urandom); while (b == CH_EOT || b == CH_SUB || b == CH_RETRY);
      offer(CMD_BYTE, b, 1'b1);
    end
    r = $urandom_range(0, 99);
    if (r < 6) begin
      offer(CMD_BYTE, CH_EOT, 1'b1);
    end else if (r < 10) begin
      offer(CMD_BYTE, CH_RETRY, 1'b1);
    end else if (r < 15) begin
      tick_burst(cur_chr);
    end else begin
      offer(CMD_BYTE, CH_SUB, 1'b1);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        offer(CMD_BYTE, CH_ACK, 1'b1);
      end else if (r < 85) begin
        do b = 8'($urandom); while (b == CH_ACK);
        offer(CMD_BYTE, b, 1'b1);
      end else begin
        tick_burst(cur_chr);
      end
    end
  endtask

  initial begin
    int          p;
    int          target;
    bit          held;
    logic [15:0] a;
    logic [15:0] c;
    held = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, with the registers at their reset values first.
    // While idle, bytes, ticks and carrier loss are all ignored.
    offer(CMD_BYTE, 8'h41, 1'b1);
    offer(CMD_TICK, 8'h00, 1'b1);
    offer(CMD_CARRIER, 8'hFF, 1'b1);
    // A clean exchange: a stray byte in the ACK wait is ignored, the two extreme
    // name bytes are taken, carrier loss and a tick in the name phase are
    // ignored, then the checksum is sent and acknowledged.
    offer(CMD_START, 8'h00, 1'b1);
    offer(CMD_BYTE, 8'h33, 1'b1);
    offer(CMD_BYTE, CH_ACK, 1'b1);
    offer(CMD_BYTE, 8'h00, 1'b1);
    offer(CMD_BYTE, 8'hFF, 1'b1);
    offer(CMD_CARRIER, 8'h00, 1'b1);
    offer(CMD_TICK, 8'h00, 1'b1);
    offer(CMD_BYTE, CH_SUB, 1'b1);
    offer(CMD_BYTE, CH_ACK, 1'b1);
    // End of batch, then carrier loss, both while waiting for the ACK.
    offer(CMD_START, 8'h00, 1'b1);
    offer(CMD_BYTE, CH_EOT, 1'b1);
    offer(CMD_START, 8'h00, 1'b1);
    offer(CMD_CARRIER, 8'h00, 1'b1);
    // A 'u' re-NAKs, a start while busy restarts, and EOT during the name
    // ends the exchange with success.
    offer(CMD_START, 8'h00, 1'b1);
    offer(CMD_BYTE, CH_ACK, 1'b1);
    offer(CMD_BYTE, CH_RETRY, 1'b1);
    offer(CMD_START, 8'h00, 1'b1);
    offer(CMD_BYTE, CH_ACK, 1'b1);
    offer(CMD_BYTE, CH_EOT, 1'b1);
    settle();
    // With a retry limit of zero the very first NAK already fails.
    apply_cfg(4'd0, 16'd0, 16'd0);
    offer(CMD_START, 8'h00, 1'b1);
    settle();
    // Zero timeouts: the first tick in either wait times out, and the third
    // NAK attempt runs into the limit of two.
    apply_cfg(4'd2, 16'd0, 16'd0);
    offer(CMD_START, 8'h00, 1'b1);
    offer(CMD_TICK, 8'h00, 1'b1);
    offer(CMD_BYTE, CH_ACK, 1'b1);
    offer(CMD_TICK, 8'h00, 1'b1);

    // Random part, in eight register settings. The first two are the extremes.
    // Between settings a start followed by carrier loss brings the block back
    // to idle from any phase before the registers are touched.
    n_sent = 0;
    for (p = 0; p < 8; p++) begin
      offer(CMD_START, 8'($urandom), 1'b0);
      offer(CMD_CARRIER, 8'($urandom), 1'b0);
      settle();
      case (p)
        0: apply_cfg(4'd1, 16'd1, 16'd1);
        1: apply_cfg(4'd15, 16'hFFFF, 16'hFFFF);
        default: begin
          a = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(1, 65535)) :
              16'($urandom_range(1, 8));
          c = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(1, 65535)) :
              16'($urandom_range(1, 8));
          apply_cfg(4'($urandom_range(1, 15)), a, c);
        end
      endcase
      target = 1650 * (p + 1) / 8;
      while (n_sent < target) begin
        // Idle pattern: a slow receiver first, then a slow sender, then
        // full speed on both sides.
        if (n_sent < 550) begin
          tx_idle_pct = 6;
          rx_idle_pct = 60;
        end else if (n_sent < 1100) begin
          tx_idle_pct = 60;
          rx_idle_pct = 6;
        end else begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
        if (!held && n_sent >= 300) begin
          held = 1'b1;
          hold_seq++;
        end
        if ($urandom_range(0, 99) < 5) begin
          repeat ($urandom_range(1, 5))
            offer(cmd_t'($urandom_range(0, 3)), 8'($urandom), 1'b0);
        end else begin
          session();
        end
      end
    end

    settle();
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/m7fr_pkg.sv
sv/m7fr_core.sv
sv/modem7_filename_receiver.sv
tb/sv/m7fr_checker.sv
tb/sv/tb_top.sv
